[rtl/sesl_pkg.sv]
// Shared types, constants and clamp helpers for the servo/ESC slew limiter.
`timescale 1ns / 1ps
`default_nettype none

package sesl_pkg;

    localparam int PULSE_W = 11;
    localparam int STEP_W  = 8;
    localparam int CMD_W   = 4;
    localparam int VAL_W   = 16;
    localparam int STAT_W  = 2;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 96;
    localparam int CFG_A_W = 1;

    localparam logic [PULSE_W-1:0] SERVO_BOUND_LO = 11'd1000;
    localparam logic [PULSE_W-1:0] SERVO_BOUND_HI = 11'd2000;
    localparam logic [PULSE_W-1:0] ESC_BOUND_LO   = 11'd1500;
    localparam logic [PULSE_W-1:0] ESC_BOUND_HI   = 11'd1700;

    localparam logic [STEP_W-1:0]  STEP_RST       = 8'd8;
    localparam logic [PULSE_W-1:0] NEUTRAL_RST    = 11'd1500;
    localparam logic [PULSE_W-1:0] SERVO_LO_RST   = 11'd1300;
    localparam logic [PULSE_W-1:0] SERVO_HI_RST   = 11'd1700;
    localparam logic [PULSE_W-1:0] ESC_LO_RST     = 11'd1500;
    localparam logic [PULSE_W-1:0] ESC_HI_RST     = 11'd1600;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK         = 4'd0,
        CMD_SERVO_SET    = 4'd1,
        CMD_SERVO_CENTER = 4'd2,
        CMD_ARM          = 4'd3,
        CMD_DISARM       = 4'd4,
        CMD_ESC_NEUTRAL  = 4'd5,
        CMD_ESC_SET      = 4'd6,
        CMD_STOP         = 4'd7,
        CMD_SERVO_LIMITS = 4'd8,
        CMD_ESC_LIMITS   = 4'd9,
        CMD_QUERY        = 4'd10
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_NOT_ARMED  = 2'd1,
        ST_ZERO_VALUE = 2'd2,
        ST_BAD_RANGE  = 2'd3
    } status_t;

    typedef enum logic [CFG_A_W-1:0] {
        REG_SLEW_STEP     = 1'b0,
        REG_NEUTRAL_PULSE = 1'b1
    } cfg_idx_t;

    // Result of one slew step on a channel.
    typedef struct packed {
        logic [PULSE_W-1:0] pulse;
        logic               moved;
    } walk_t;

    // Clamp a signed request into an unsigned pulse range.
    function automatic logic [PULSE_W-1:0] clamp_req(
        input logic signed [VAL_W-1:0] v,
        input logic [PULSE_W-1:0]      lo,
        input logic [PULSE_W-1:0]      hi
    );
        logic signed [VAL_W:0] vx;
        logic signed [VAL_W:0] lox;
        logic signed [VAL_W:0] hix;
        vx  = {v[VAL_W-1], v};
        lox = $signed({{(VAL_W+1-PULSE_W){1'b0}}, lo});
        hix = $signed({{(VAL_W+1-PULSE_W){1'b0}}, hi});
        if (vx < lox) begin
            return lo;
        end else if (vx > hix) begin
            return hi;
        end else begin
            return v[PULSE_W-1:0];
        end
    endfunction

    function automatic logic [PULSE_W-1:0] clamp_pulse(
        input logic [PULSE_W-1:0] v,
        input logic [PULSE_W-1:0] lo,
        input logic [PULSE_W-1:0] hi
    );
        if (v < lo) begin
            return lo;
        end else if (v > hi) begin
            return hi;
        end else begin
            return v;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/servo_esc_slew_limiter_unit.sv]
// Top level of the two-channel servo/ESC slew limiter.
// Steering and throttle pulse widths are held here and changed by command
// transactions on the s_ stream; every accepted command returns exactly one
// status transaction on the m_ stream carrying the state after the command.
// A command is taken in every cycle in which the output register is empty
// or being drained, so throughput is one transaction per clock; the
// command decode, the clamps and the per-channel slew step form a single
// combinational pass into the state and result registers. s_tready is
// held low during reset. s_tuser[3:0] carries the command code; codes 11
// to 15 behave as query. Tick (code 0) walks each pulse toward its goal by
// at most slew_step us; while disarmed the throttle walks toward
// neutral_pulse.
// Configuration writes (index 0 slew_step, 1 neutral_pulse) take effect on
// the next command and move no state by themselves; write them only when
// the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module servo_esc_slew_limiter_unit
    import sesl_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // config write port
    input  wire logic               cfg_wr_en,
    input  wire logic [CFG_A_W-1:0] cfg_wr_addr,
    input  wire logic [PULSE_W-1:0] cfg_wr_data,
    // command stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // s_tdata: value[15:0], limit_low[31:16], limit_high[47:32]
    input  wire logic [IN_W-1:0]    s_tdata,
    // s_tuser: cmd[3:0]
    input  wire logic [CMD_W-1:0]   s_tuser,
    // status stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // m_tdata: status[1:0], servo_pulse[12:2], servo_goal[23:13],
    //   esc_pulse[34:24], esc_goal[45:35], armed[46], servo_lo[57:47],
    //   servo_hi[68:58], esc_lo[79:69], esc_hi[90:80], servo_moved[91],
    //   esc_moved[92], zero[95:93]
    output logic [OUT_W-1:0]        m_tdata
);

    // registers
    logic [STEP_W-1:0]  step_reg;
    logic [PULSE_W-1:0] neutral_reg;
    logic [PULSE_W-1:0] servo_cur_reg, servo_cur_next;
    logic [PULSE_W-1:0] servo_tgt_reg, servo_tgt_next;
    logic [PULSE_W-1:0] esc_cur_reg,   esc_cur_next;
    logic [PULSE_W-1:0] esc_tgt_reg,   esc_tgt_next;
    logic               armed_reg,     armed_next;
    logic [PULSE_W-1:0] servo_lo_reg,  servo_lo_next;
    logic [PULSE_W-1:0] servo_hi_reg,  servo_hi_next;
    logic [PULSE_W-1:0] esc_lo_reg,    esc_lo_next;
    logic [PULSE_W-1:0] esc_hi_reg,    esc_hi_next;
    logic               m_valid_reg;
    logic [OUT_W-1:0]   m_data_reg,    m_data_next;

    logic                    s_accept;
    cmd_t                    cmd;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] lim_lo;
    logic signed [VAL_W-1:0] lim_hi;
    status_t                 status;
    logic                    smoved;
    logic                    emoved;
    logic [PULSE_W-1:0]      esc_goal;
    walk_t                   servo_walk;
    walk_t                   esc_walk;

    // Output register frees the input side whenever it drains.
    assign s_tready = aresetn && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign cmd    = cmd_t'(s_tuser);
    assign value  = $signed(s_tdata[15:0]);
    assign lim_lo = $signed(s_tdata[31:16]);
    assign lim_hi = $signed(s_tdata[47:32]);

    // disarmed throttle idles toward neutral
    assign esc_goal = armed_reg ? esc_tgt_reg : neutral_reg;

    sesl_walk u_servo_walk (
        .now  (servo_cur_reg),
        .goal (servo_tgt_reg),
        .step (step_reg),
        .res  (servo_walk)
    );

    sesl_walk u_esc_walk (
        .now  (esc_cur_reg),
        .goal (esc_goal),
        .step (step_reg),
        .res  (esc_walk)
    );

    always_comb begin
        servo_cur_next = servo_cur_reg;
        servo_tgt_next = servo_tgt_reg;
        esc_cur_next   = esc_cur_reg;
        esc_tgt_next   = esc_tgt_reg;
        armed_next     = armed_reg;
        servo_lo_next  = servo_lo_reg;
        servo_hi_next  = servo_hi_reg;
        esc_lo_next    = esc_lo_reg;
        esc_hi_next    = esc_hi_reg;
        status         = ST_OK;
        smoved         = 1'b0;
        emoved         = 1'b0;

        unique case (cmd)
            CMD_TICK: begin
                servo_cur_next = servo_walk.pulse;
                esc_cur_next   = esc_walk.pulse;
                smoved         = servo_walk.moved;
                emoved         = esc_walk.moved;
            end
            CMD_SERVO_SET: begin
                if (value == '0) begin
                    status = ST_ZERO_VALUE;
                end else begin
                    servo_tgt_next = clamp_req(value, servo_lo_reg, servo_hi_reg);
                end
            end
            CMD_SERVO_CENTER: begin
                servo_tgt_next = neutral_reg;
            end
            CMD_ARM: begin
                armed_next   = 1'b1;
                esc_tgt_next = neutral_reg;
            end
            CMD_DISARM: begin
                armed_next   = 1'b0;
                esc_tgt_next = neutral_reg;
            end
            CMD_ESC_NEUTRAL: begin
                esc_tgt_next = neutral_reg;
            end
            CMD_ESC_SET: begin
                if (!armed_reg) begin
                    status = ST_NOT_ARMED;
                end else if (value == '0) begin
                    status = ST_ZERO_VALUE;
                end else begin
                    esc_tgt_next = clamp_req(value, esc_lo_reg, esc_hi_reg);
                end
            end
            CMD_STOP: begin
                armed_next     = 1'b0;
                esc_tgt_next   = neutral_reg;
                servo_tgt_next = neutral_reg;
                esc_cur_next   = neutral_reg;
                servo_cur_next = neutral_reg;
                smoved         = 1'b1;
                emoved         = 1'b1;
            end
            CMD_SERVO_LIMITS: begin
                if (lim_lo >= lim_hi) begin
                    status = ST_BAD_RANGE;
                end else begin
                    servo_lo_next  = clamp_req(lim_lo, SERVO_BOUND_LO, SERVO_BOUND_HI);
                    servo_hi_next  = clamp_req(lim_hi, SERVO_BOUND_LO, SERVO_BOUND_HI);
                    servo_tgt_next = clamp_pulse(servo_tgt_reg, servo_lo_next,
                                                 servo_hi_next);
                end
            end
            CMD_ESC_LIMITS: begin
                if (lim_lo >= lim_hi) begin
                    status = ST_BAD_RANGE;
                end else begin
                    esc_lo_next  = clamp_req(lim_lo, ESC_BOUND_LO, ESC_BOUND_HI);
                    esc_hi_next  = clamp_req(lim_hi, ESC_BOUND_LO, ESC_BOUND_HI);
                    esc_tgt_next = clamp_pulse(esc_tgt_reg, esc_lo_next, esc_hi_next);
                end
            end
            default: begin
                // query and unused codes: report only
            end
        endcase

        m_data_next = {3'b000, emoved, smoved, esc_hi_next, esc_lo_next,
                       servo_hi_next, servo_lo_next, armed_next, esc_tgt_next,
                       esc_cur_next, servo_tgt_next, servo_cur_next, status};
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= STEP_RST;
            neutral_reg <= NEUTRAL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_wr_addr))
                REG_SLEW_STEP:     step_reg    <= cfg_wr_data[STEP_W-1:0];
                REG_NEUTRAL_PULSE: neutral_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // channel state, updated once per accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            servo_cur_reg <= NEUTRAL_RST;
            servo_tgt_reg <= NEUTRAL_RST;
            esc_cur_reg   <= NEUTRAL_RST;
            esc_tgt_reg   <= NEUTRAL_RST;
            armed_reg     <= 1'b0;
            servo_lo_reg  <= SERVO_LO_RST;
            servo_hi_reg  <= SERVO_HI_RST;
            esc_lo_reg    <= ESC_LO_RST;
            esc_hi_reg    <= ESC_HI_RST;
        end else if (s_accept) begin
            servo_cur_reg <= servo_cur_next;
            servo_tgt_reg <= servo_tgt_next;
            esc_cur_reg   <= esc_cur_next;
            esc_tgt_reg   <= esc_tgt_next;
            armed_reg     <= armed_next;
            servo_lo_reg  <= servo_lo_next;
            servo_hi_reg  <= servo_hi_next;
            esc_lo_reg    <= esc_lo_next;
            esc_hi_reg    <= esc_hi_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= m_data_next;
        end
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // rejected commands never report motion
    a_reject_no_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[1:0] != ST_OK) |-> !(m_data_reg[91] || m_data_reg[92]))
        else $error("motion reported on rejected command");

    // stop lands both pulses on the same neutral and disarms
    a_stop_snap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && cmd == CMD_STOP) |=>
            (servo_cur_reg == esc_cur_reg) && !armed_reg)
        else $error("stop did not snap to neutral");

    // working limits stay ordered and inside the hard bounds
    a_servo_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (servo_lo_reg <= servo_hi_reg) && (servo_lo_reg >= SERVO_BOUND_LO)
            && (servo_hi_reg <= SERVO_BOUND_HI))
        else $error("servo limits out of range");

    a_esc_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (esc_lo_reg <= esc_hi_reg) && (esc_lo_reg >= ESC_BOUND_LO)
            && (esc_hi_reg <= ESC_BOUND_HI))
        else $error("esc limits out of range");

    // a finished result is never overwritten while stalled
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> m_valid_reg && $stable(m_data_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire

[rtl/sesl_walk.sv]
// One bounded slew step of a pulse toward its goal.
`timescale 1ns / 1ps
`default_nettype none

module sesl_walk
    import sesl_pkg::*;
(
    input  wire logic [PULSE_W-1:0] now,
    input  wire logic [PULSE_W-1:0] goal,
    input  wire logic [STEP_W-1:0]  step,
    output walk_t                   res
);

    logic signed [PULSE_W:0] diff;
    logic signed [PULSE_W:0] step_s;

    assign diff   = $signed({1'b0, goal}) - $signed({1'b0, now});
    assign step_s = $signed({{(PULSE_W+1-STEP_W){1'b0}}, step});

    always_comb begin
        res.pulse = now;
        res.moved = 1'b0;
        if (diff != '0 && step != '0) begin
            res.moved = 1'b1;
            if (diff > step_s) begin
                res.pulse = now + {{(PULSE_W-STEP_W){1'b0}}, step};
            end else if (diff < -step_s) begin
                res.pulse = now - {{(PULSE_W-STEP_W){1'b0}}, step};
            end else begin
                res.pulse = goal;
            end
        end
    end

endmodule

`default_nettype wire
